### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every check is sampled on clk and held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a condition.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/core/pso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_pkg: shared constants and helpers for the polyline stroke offsetter
// Field widths, arithmetic widths of the shared unit and coordinate clamping.
// ----------------------------------------------------------------------------
package pso_pkg;

  // Field widths
  localparam int COORD_W   = 16;  // Q12.4 coordinate
  localparam int FRAC_BITS = 4;   // fraction bits of a coordinate
  localparam int THICK_W   = 8;   // fixed thickness, whole pixels
  localparam int WIDTH_W   = THICK_W + FRAC_BITS;  // half-width, 12 bits

  // Configuration register indexes
  localparam logic REG_WIDTH_MODE  = 1'b0;
  localparam logic REG_FIXED_THICK = 1'b1;
  localparam logic [THICK_W-1:0] FIXED_THICK_RESET = 8'd1;

  // Vertex counter saturates here
  localparam logic [1:0] SEEN_MAX = 2'd2;

  // Arithmetic widths
  localparam int DIFF_W  = COORD_W + 1;        // direction component
  localparam int MAG_W   = COORD_W;            // |direction component|
  localparam int L2_W    = 2 * MAG_W + 1;      // dx^2 + dy^2
  localparam int OP_W    = WIDTH_W + MAG_W;    // multiplier operand (w*a)
  localparam int PROD_W  = 2 * OP_W;           // multiplier result
  localparam int QUO_W   = 2 * WIDTH_W + 2;    // floor(4 w^2 a^2 / L2) < 2^26
  localparam int ROOT_W  = QUO_W / 2;          // isqrt of the quotient
  localparam int SQREM_W = ROOT_W + 2;         // square root remainder
  localparam int SUM_W   = COORD_W + 2;        // center +/- offset
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  // Clamp a widened coordinate sum to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
    logic [COORD_W-1:0] r;
    if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/core/polyline_stroke_offsetter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_offsetter: polyline vertices to triangle strip points
// Offsets each vertex along the unit normal of its neighbor difference.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices enter on the in_valid/in_ready channel, one transfer each; strip
//   points leave on out_valid/out_ready, two per center vertex (side 0 is
//   center plus offset, side 1 center minus offset). Output lags one vertex:
//   the first vertex of a polyline gives nothing unless flagged last_vertex,
//   later ones give the pair of the held vertex, and a vertex flagged
//   last_vertex also flushes its own pair, the final point carrying strip_end.
//   The block takes one vertex at a time; in_ready is low until all its points
//   are transferred. A pair with a nonzero direction takes two components,
//   each a w*a and a squaring pass on the multiplier, a restoring divide and
//   a square root on the shared unit; a pair with a zero direction skips
//   these passes. An output stall holds the block as well.
//   When the receiver stalls, the current point holds on the output ports.
//   Reset clears the vertex history, width_mode to 0 and fixed_thickness to 1.
//   Write configuration through cfg_write only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyline_stroke_offsetter (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [pso_pkg::THICK_W-1:0]          cfg_data,
  // vertex input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pso_pkg::COORD_W-1:0]   vertex_x,
  input  logic signed [pso_pkg::COORD_W-1:0]   vertex_y,
  input  logic [pso_pkg::WIDTH_W-1:0]          vertex_width,
  input  logic                                 last_vertex,
  // strip output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pso_pkg::COORD_W-1:0]   out_x,
  output logic signed [pso_pkg::COORD_W-1:0]   out_y,
  output logic [pso_pkg::WIDTH_W-1:0]          out_z,
  output logic                                 side,
  output logic                                 strip_end
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_WA, S_NSQ, S_DLD,
    S_DIV, S_SQRT, S_ROUND, S_LOAD, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic                           width_mode;
  logic [pso_pkg::THICK_W-1:0]    fixed_thickness;

  // vertex history
  logic [pso_pkg::COORD_W-1:0]    earlier_x, earlier_y;
  logic [pso_pkg::COORD_W-1:0]    held_x, held_y;
  logic [pso_pkg::WIDTH_W-1:0]    held_width;
  logic [1:0]                     vertices_seen;

  // pair in work
  logic [pso_pkg::COORD_W-1:0]    cur_x, cur_y;
  logic [pso_pkg::WIDTH_W-1:0]    cur_z;
  logic [pso_pkg::DIFF_W-1:0]     cur_dx, cur_dy;
  logic                           cur_end;

  // flush pair queued behind it
  logic                           have_b;
  logic [pso_pkg::COORD_W-1:0]    nb_x, nb_y;
  logic [pso_pkg::WIDTH_W-1:0]    nb_z;
  logic [pso_pkg::DIFF_W-1:0]     nb_dx, nb_dy;

  // shared unit registers
  logic                           comp;     // 0: x offset, 1: y offset
  logic [pso_pkg::PROD_W-1:0]     prod;
  logic [pso_pkg::L2_W-1:0]       l2;
  logic [pso_pkg::L2_W-1:0]       rem;
  logic [pso_pkg::QUO_W-1:0]      dvd;
  logic [pso_pkg::SQREM_W-1:0]    sq_rem;
  logic [pso_pkg::ROOT_W-1:0]     root;
  logic [pso_pkg::CNT_W-1:0]      cnt;
  logic [pso_pkg::WIDTH_W-1:0]    mag_x, mag_y;

  // combinational datapath
  logic [pso_pkg::DIFF_W-1:0]     dx_neg, dy_neg;
  logic [pso_pkg::MAG_W-1:0]      ax, ay, a_sel;
  logic [pso_pkg::WIDTH_W-1:0]    w_eff;
  logic [pso_pkg::OP_W-1:0]       mul_a, mul_b;
  logic [pso_pkg::PROD_W-1:0]     mul_out;
  logic [pso_pkg::L2_W:0]         div_t, div_diff;
  logic                           div_ge;
  logic [pso_pkg::SQREM_W+1:0]    sq_raw, sq_trial, sq_diff;
  logic                           sq_ge;
  logic [pso_pkg::ROOT_W:0]       root_sum;
  logic                           dy_pos;
  logic [pso_pkg::SUM_W-1:0]      off_x, off_y, cx_ext, cy_ext;
  logic [pso_pkg::DIFF_W-1:0]     in_dx_e, in_dy_e, in_dx_h, in_dy_h;

  // Direction magnitudes and effective half-width
  always_comb begin
    dx_neg = -cur_dx;
    dy_neg = -cur_dy;
    ax = cur_dx[pso_pkg::DIFF_W-1] ? dx_neg[pso_pkg::MAG_W-1:0] : cur_dx[pso_pkg::MAG_W-1:0];
    ay = cur_dy[pso_pkg::DIFF_W-1] ? dy_neg[pso_pkg::MAG_W-1:0] : cur_dy[pso_pkg::MAG_W-1:0];
    a_sel = comp ? ax : ay;
    w_eff = width_mode ? {fixed_thickness, {pso_pkg::FRAC_BITS{1'b0}}} : cur_z;
  end

  // Shared multiplier, operands picked by the sequencer
  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = pso_pkg::OP_W'(ax);
        mul_b = pso_pkg::OP_W'(ax);
      end
      S_SQY: begin
        mul_a = pso_pkg::OP_W'(ay);
        mul_b = pso_pkg::OP_W'(ay);
      end
      S_WA: begin
        mul_a = pso_pkg::OP_W'(w_eff);
        mul_b = pso_pkg::OP_W'(a_sel);
      end
      S_NSQ: begin
        mul_a = prod[pso_pkg::OP_W-1:0];
        mul_b = prod[pso_pkg::OP_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_out = mul_a * mul_b;
  end

  // Restoring divide step and square root step
  always_comb begin
    div_t    = {rem, dvd[pso_pkg::QUO_W-1]};
    div_diff = div_t - {1'b0, l2};
    div_ge   = (div_t >= {1'b0, l2});
    sq_raw   = {sq_rem, dvd[pso_pkg::QUO_W-1 -: 2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_diff  = sq_raw - sq_trial;
    sq_ge    = (sq_raw >= sq_trial);
    root_sum = {1'b0, root} + {{pso_pkg::ROOT_W{1'b0}}, 1'b1};
  end

  // Signed offsets and widened centers
  always_comb begin
    dy_pos = !cur_dy[pso_pkg::DIFF_W-1] && (cur_dy != '0);
    off_x  = {{(pso_pkg::SUM_W-pso_pkg::WIDTH_W){1'b0}}, mag_x};
    off_y  = {{(pso_pkg::SUM_W-pso_pkg::WIDTH_W){1'b0}}, mag_y};
    if (dy_pos) begin
      off_x = -off_x;
    end
    if (cur_dx[pso_pkg::DIFF_W-1]) begin
      off_y = -off_y;
    end
    cx_ext = {{2{cur_x[pso_pkg::COORD_W-1]}}, cur_x};
    cy_ext = {{2{cur_y[pso_pkg::COORD_W-1]}}, cur_y};
  end

  // Direction differences at the input
  always_comb begin
    in_dx_e = {vertex_x[pso_pkg::COORD_W-1], vertex_x} - {earlier_x[pso_pkg::COORD_W-1], earlier_x};
    in_dy_e = {vertex_y[pso_pkg::COORD_W-1], vertex_y} - {earlier_y[pso_pkg::COORD_W-1], earlier_y};
    in_dx_h = {vertex_x[pso_pkg::COORD_W-1], vertex_x} - {held_x[pso_pkg::COORD_W-1], held_x};
    in_dy_h = {vertex_y[pso_pkg::COORD_W-1], vertex_y} - {held_y[pso_pkg::COORD_W-1], held_y};
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer, history and output registers
  always_ff @(posedge clk) begin
    prod <= mul_out;
    if (rst) begin
      state           <= S_IDLE;
      width_mode      <= 1'b0;
      fixed_thickness <= pso_pkg::FIXED_THICK_RESET;
      earlier_x       <= '0;
      earlier_y       <= '0;
      held_x          <= '0;
      held_y          <= '0;
      held_width      <= '0;
      vertices_seen   <= '0;
      have_b          <= 1'b0;
      comp            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          pso_pkg::REG_WIDTH_MODE:  width_mode <= cfg_data[0];
          pso_pkg::REG_FIXED_THICK: fixed_thickness <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            comp <= 1'b0;
            if (vertices_seen == '0) begin
              if (last_vertex) begin
                // lone vertex: zero direction, ends the strip
                cur_x   <= vertex_x;
                cur_y   <= vertex_y;
                cur_z   <= vertex_width;
                cur_dx  <= '0;
                cur_dy  <= '0;
                cur_end <= 1'b1;
                have_b  <= 1'b0;
                state   <= S_SQX;
              end else begin
                earlier_x     <= vertex_x;
                earlier_y     <= vertex_y;
                held_x        <= vertex_x;
                held_y        <= vertex_y;
                held_width    <= vertex_width;
                vertices_seen <= 2'd1;
              end
            end else begin
              // emit the held vertex
              cur_x   <= held_x;
              cur_y   <= held_y;
              cur_z   <= held_width;
              cur_dx  <= in_dx_e;
              cur_dy  <= in_dy_e;
              cur_end <= 1'b0;
              state   <= S_SQX;
              if (last_vertex) begin
                // queue the flush pair and restart the history
                have_b        <= 1'b1;
                nb_x          <= vertex_x;
                nb_y          <= vertex_y;
                nb_z          <= vertex_width;
                nb_dx         <= in_dx_h;
                nb_dy         <= in_dy_h;
                earlier_x     <= '0;
                earlier_y     <= '0;
                held_x        <= '0;
                held_y        <= '0;
                held_width    <= '0;
                vertices_seen <= '0;
              end else begin
                have_b     <= 1'b0;
                earlier_x  <= held_x;
                earlier_y  <= held_y;
                held_x     <= vertex_x;
                held_y     <= vertex_y;
                held_width <= vertex_width;
                if (vertices_seen != pso_pkg::SEEN_MAX) begin
                  vertices_seen <= vertices_seen + 2'd1;
                end
              end
            end
          end
        end

        // squared length of the direction
        S_SQX: state <= S_SQY;
        S_SQY: begin
          l2    <= pso_pkg::L2_W'(prod);
          state <= S_SUM;
        end
        S_SUM: begin
          l2    <= l2 + pso_pkg::L2_W'(prod);
          state <= S_WA;
        end

        // w * a, or the fixed (0, w) offset for a zero direction
        S_WA: begin
          if (l2 == '0) begin
            mag_x <= '0;
            mag_y <= w_eff;
            state <= S_LOAD;
          end else begin
            state <= S_NSQ;
          end
        end
        S_NSQ: state <= S_DLD;

        // load 4 (w a)^2; the top part is already below L2
        S_DLD: begin
          rem   <= {1'b0, prod[pso_pkg::PROD_W-1 -: pso_pkg::L2_W-1]};
          dvd   <= {prod[pso_pkg::QUO_W-3:0], 2'b00};
          cnt   <= '0;
          state <= S_DIV;
        end

        // one quotient bit per cycle
        S_DIV: begin
          rem <= div_ge ? div_diff[pso_pkg::L2_W-1:0] : div_t[pso_pkg::L2_W-1:0];
          dvd <= {dvd[pso_pkg::QUO_W-2:0], div_ge};
          if (cnt == pso_pkg::CNT_W'(pso_pkg::DIV_STEPS - 1)) begin
            cnt    <= '0;
            sq_rem <= '0;
            root   <= '0;
            state  <= S_SQRT;
          end else begin
            cnt <= cnt + pso_pkg::CNT_W'(1);
          end
        end

        // one root bit per cycle
        S_SQRT: begin
          sq_rem <= sq_ge ? sq_diff[pso_pkg::SQREM_W-1:0] : sq_raw[pso_pkg::SQREM_W-1:0];
          root   <= {root[pso_pkg::ROOT_W-2:0], sq_ge};
          dvd    <= {dvd[pso_pkg::QUO_W-3:0], 2'b00};
          cnt    <= cnt + pso_pkg::CNT_W'(1);
          if (cnt == pso_pkg::CNT_W'(pso_pkg::SQRT_STEPS - 1)) begin
            state <= S_ROUND;
          end
        end

        // largest odd t <= root gives the rounded magnitude (t + 1) / 2
        S_ROUND: begin
          if (comp) begin
            mag_y <= root_sum[pso_pkg::WIDTH_W:1];
            state <= S_LOAD;
          end else begin
            mag_x <= root_sum[pso_pkg::WIDTH_W:1];
            comp  <= 1'b1;
            state <= S_WA;
          end
        end

        // present side 0
        S_LOAD: begin
          out_x     <= pso_pkg::sat_coord(cx_ext + off_x);
          out_y     <= pso_pkg::sat_coord(cy_ext + off_y);
          out_z     <= cur_z;
          side      <= 1'b0;
          strip_end <= 1'b0;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end

        // hold each point until transferred
        S_OUT: begin
          if (out_ready) begin
            if (!side) begin
              out_x     <= pso_pkg::sat_coord(cx_ext - off_x);
              out_y     <= pso_pkg::sat_coord(cy_ext - off_y);
              side      <= 1'b1;
              strip_end <= cur_end;
            end else begin
              out_valid <= 1'b0;
              comp      <= 1'b0;
              if (have_b) begin
                cur_x   <= nb_x;
                cur_y   <= nb_y;
                cur_z   <= nb_z;
                cur_dx  <= nb_dx;
                cur_dy  <= nb_dy;
                cur_end <= 1'b1;
                have_b  <= 1'b0;
                state   <= S_SQX;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_busy_excl, !(in_ready && out_valid), "input taken while a point is pending")
  `ASSERT_ALWAYS(a_end_side1, !(out_valid && strip_end && !side), "strip end on a side 0 point")
  `ASSERT_NEXT(a_pair_order, out_valid && out_ready && !side, out_valid && side, "side 1 point missing")
  `ASSERT_NEXT(a_restart, in_valid && in_ready && last_vertex, vertices_seen == '0, "history kept after last vertex")

endmodule

### sim/strip_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_point_checker: scoreboard for the polyline stroke offsetter
// Watches the register port and both channels, predicts the strip points of
// every vertex transfer and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module strip_point_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [pso_pkg::THICK_W-1:0]         cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [pso_pkg::COORD_W-1:0]  vertex_x,
  input  logic signed [pso_pkg::COORD_W-1:0]  vertex_y,
  input  logic [pso_pkg::WIDTH_W-1:0]         vertex_width,
  input  logic                                last_vertex,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [pso_pkg::COORD_W-1:0]  out_x,
  input  logic signed [pso_pkg::COORD_W-1:0]  out_y,
  input  logic [pso_pkg::WIDTH_W-1:0]         out_z,
  input  logic                                side,
  input  logic                                strip_end,
  output int                                  mismatch_count,
  output int                                  points_due
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [pso_pkg::COORD_W-1:0] x;
    logic signed [pso_pkg::COORD_W-1:0] y;
    logic [pso_pkg::WIDTH_W-1:0]        z;
    logic                               side;
    logic                               strip_end;
  } strip_point_t;

  strip_point_t expected_points[$];

  // Shadow of the registers and of the vertex history
  logic                        width_mode;
  logic [pso_pkg::THICK_W-1:0] fixed_thick;
  int                          prior_x, prior_y;
  int                          center_x, center_y;
  logic [pso_pkg::WIDTH_W-1:0] center_width;
  logic [1:0]                  seen;

  initial begin
    mismatch_count = 0;
    points_due     = 0;
  end

  // round(w * a / sqrt(l2)) with ties away from zero, found as the largest q
  // in [0, w] with (2q - 1)^2 * l2 <= (2 w a)^2
  function automatic u64_t normal_part(u64_t w, u64_t a, u64_t l2);
    u64_t rhs, lo, hi, q, t;
    rhs = 2 * w * a;
    rhs = rhs * rhs;
    lo  = 0;
    hi  = w;
    while (lo < hi) begin
      q = (lo + hi + 1) / 2;
      t = 2 * q - 1;
      if (t * t * l2 <= rhs) lo = q;
      else hi = q - 1;
    end
    return lo;
  endfunction

  function automatic logic signed [pso_pkg::COORD_W-1:0] clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[pso_pkg::COORD_W-1:0];
  endfunction

  // Queue the two strip points of one center vertex
  function automatic void predict_pair(int cx, int cy, logic [pso_pkg::WIDTH_W-1:0] z,
                                       int dx, int dy, logic ends);
    u64_t         w, ax, ay, l2;
    int           ox, oy, mx, my;
    strip_point_t p;
    if (width_mode) begin
      w = u64_t'(fixed_thick);
      w = w << pso_pkg::FRAC_BITS;
    end else begin
      w = u64_t'(z);
    end
    ax = u64_t'((dx < 0) ? -dx : dx);
    ay = u64_t'((dy < 0) ? -dy : dy);
    l2 = ax * ax + ay * ay;
    ox = 0;
    oy = int'(w);
    if (l2 != 0) begin
      mx = int'(normal_part(w, ay, l2));
      my = int'(normal_part(w, ax, l2));
      ox = (dy > 0) ? -mx : mx;
      oy = (dx < 0) ? -my : my;
    end
    p.x = clamp_coord(cx + ox);
    p.y = clamp_coord(cy + oy);
    p.z = z;
    p.side = 1'b0;
    p.strip_end = 1'b0;
    expected_points = {expected_points, p};
    p.x = clamp_coord(cx - ox);
    p.y = clamp_coord(cy - oy);
    p.side = 1'b1;
    p.strip_end = ends;
    expected_points = {expected_points, p};
  endfunction

  function automatic void clear_history();
    prior_x      = 0;
    prior_y      = 0;
    center_x     = 0;
    center_y     = 0;
    center_width = '0;
    seen         = '0;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    int           vx, vy;
    strip_point_t want;
    if (rst) begin
      width_mode  = 1'b0;
      fixed_thick = pso_pkg::FIXED_THICK_RESET;
      clear_history();
      expected_points.delete();
    end else begin
      // Predict the points released by a vertex transfer
      if (in_valid && in_ready) begin
        vx = int'(vertex_x);
        vy = int'(vertex_y);
        if (seen == 2'd0) begin
          if (last_vertex) begin
            predict_pair(vx, vy, vertex_width, 0, 0, 1'b1);
            clear_history();
          end else begin
            prior_x      = vx;
            prior_y      = vy;
            center_x     = vx;
            center_y     = vy;
            center_width = vertex_width;
            seen         = 2'd1;
          end
        end else begin
          predict_pair(center_x, center_y, center_width,
                       vx - prior_x, vy - prior_y, 1'b0);
          if (last_vertex) begin
            predict_pair(vx, vy, vertex_width, vx - center_x, vy - center_y, 1'b1);
            clear_history();
          end else begin
            prior_x      = center_x;
            prior_y      = center_y;
            center_x     = vx;
            center_y     = vy;
            center_width = vertex_width;
            if (seen < pso_pkg::SEEN_MAX) seen = seen + 2'd1;
          end
        end
      end

      // Register writes land after any vertex at the same edge
      if (cfg_write) begin
        if (cfg_index == pso_pkg::REG_WIDTH_MODE) width_mode = cfg_data[0];
        else fixed_thick = cfg_data;
      end

      // Compare each point transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          note_mismatch($sformatf(
            "unexpected point: x=%0d y=%0d z=%0d side=%0b end=%0b",
            out_x, out_y, out_z, side, strip_end));
        end else begin
          want = expected_points.pop_front();
          if (want.x !== out_x || want.y !== out_y || want.z !== out_z ||
              want.side !== side || want.strip_end !== strip_end) begin
            note_mismatch($sformatf(
              {"point mismatch: expected x=%0d y=%0d z=%0d side=%0b end=%0b, ",
               "got x=%0d y=%0d z=%0d side=%0b end=%0b"},
              want.x, want.y, want.z, want.side, want.strip_end,
              out_x, out_y, out_z, side, strip_end));
          end
        end
      end
    end
    points_due = expected_points.size();
  end

endmodule

### sim/polyline_stroke_offsetter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_offsetter_tb: stimulus and verdict for the stroke offsetter
// Sends directed and random polylines under several width settings with
// random gaps on both channels; the strip point checker does the comparing.
// ----------------------------------------------------------------------------
module polyline_stroke_offsetter_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 250;   // beyond the slowest vertex

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic                               cfg_index = pso_pkg::REG_WIDTH_MODE;
  logic [pso_pkg::THICK_W-1:0]        cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [pso_pkg::COORD_W-1:0] vertex_x = '0;
  logic signed [pso_pkg::COORD_W-1:0] vertex_y = '0;
  logic [pso_pkg::WIDTH_W-1:0]        vertex_width = '0;
  logic                               last_vertex = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [pso_pkg::COORD_W-1:0] out_x;
  logic signed [pso_pkg::COORD_W-1:0] out_y;
  logic [pso_pkg::WIDTH_W-1:0]        out_z;
  logic                               side;
  logic                               strip_end;

  int   mismatch_count;
  int   points_due;
  logic steady_flow = 1'b0;  // when set, neither side idles
  int   stall_left = 0;
  int   cycle_count = 0;
  int   vertices_sent = 0;

  polyline_stroke_offsetter dut (.*);

  strip_point_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("polyline_stroke_offsetter_tb: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the point receiver at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Present one vertex and hold it until the transfer; ends on a falling edge
  task automatic send_vertex(logic signed [pso_pkg::COORD_W-1:0] x,
                             logic signed [pso_pkg::COORD_W-1:0] y,
                             logic [pso_pkg::WIDTH_W-1:0] w, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vertex_x     <= x;
    vertex_y     <= y;
    vertex_width <= w;
    last_vertex  <= last;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    vertices_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted point has left
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (points_due != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [pso_pkg::THICK_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [pso_pkg::WIDTH_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return pso_pkg::WIDTH_W'($urandom);
  endfunction

  // One polyline: mostly a walk with random steps, plus jumps, extremes,
  // repeats and revisits that give zero directions
  task automatic send_random_polyline();
    int                                 len, r, reach;
    logic signed [pso_pkg::COORD_W-1:0] px, py, bx, by, bbx, bby;
    r = $urandom_range(0, 99);
    if (r < 15) len = 1;
    else if (r < 85) len = $urandom_range(2, 6);
    else len = $urandom_range(7, 12);
    case ($urandom_range(0, 3))
      0: reach = 4;
      1: reach = 64;
      2: reach = 1024;
      default: reach = 40000;
    endcase
    px = pso_pkg::COORD_W'($urandom);
    py = pso_pkg::COORD_W'($urandom);
    bx = px; by = py; bbx = px; bby = py;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        px = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        py = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end else if (r < 18) begin
        px = pso_pkg::COORD_W'($urandom);
        py = pso_pkg::COORD_W'($urandom);
      end else if (r < 24) begin
        px = bx;
        py = by;
      end else if (r < 30) begin
        px = bbx;
        py = bby;
      end else begin
        px = px + pso_pkg::COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
        py = py + pso_pkg::COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
      end
      send_vertex(px, py, pick_width(), i == len - 1);
      bbx = bx; bby = by;
      bx = px; by = py;
    end
  endtask

  initial begin
    int goal;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Width from the vertex: single vertices, saturation, zero directions
    send_vertex(16'sd0, 16'sd0, 12'hfff, 1'b1);
    send_vertex(16'sh7fff, 16'sh8000, 12'hfff, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 12'h000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 12'hfff, 1'b1);
    send_vertex(16'sd100, 16'sd100, 12'd37, 1'b0);
    send_vertex(16'sd200, 16'sd50, 12'd1, 1'b0);
    send_vertex(16'sd100, 16'sd100, 12'h800, 1'b0);
    send_vertex(16'sd100, 16'sd100, 12'hfff, 1'b1);
    send_vertex(16'sd16, 16'sd0, 12'haaa, 1'b0);
    send_vertex(16'sd16, 16'sh8000, 12'h555, 1'b0);
    send_vertex(16'sh8000, 16'sd5, 12'd3, 1'b1);
    wait_quiet();

    // Fixed thickness at its largest
    write_reg(pso_pkg::REG_WIDTH_MODE, 8'd1);
    write_reg(pso_pkg::REG_FIXED_THICK, 8'd255);
    send_vertex(16'sh7fff, 16'sh7fff, 12'h000, 1'b0);
    send_vertex(16'sh7f00, 16'sh8000, 12'h555, 1'b0);
    send_vertex(16'sh8000, 16'sd0, 12'haaa, 1'b1);
    send_vertex(16'sd0, 16'sd0, 12'd5, 1'b1);
    wait_quiet();

    // Fixed thickness of zero
    write_reg(pso_pkg::REG_FIXED_THICK, 8'd0);
    send_vertex(-16'sd5, 16'sd7, 12'd99, 1'b0);
    send_vertex(16'sd9, -16'sd3, 12'd99, 1'b1);
    wait_quiet();

    // Random polylines, one register setting per phase
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_reg(pso_pkg::REG_WIDTH_MODE, 8'd0);
        1: begin
          write_reg(pso_pkg::REG_WIDTH_MODE, 8'd1);
          write_reg(pso_pkg::REG_FIXED_THICK, pso_pkg::THICK_W'($urandom_range(1, 254)));
        end
        2: begin
          write_reg(pso_pkg::REG_FIXED_THICK, 8'd255);
          steady_flow = 1'b1;
        end
        default: begin
          steady_flow = 1'b0;
          write_reg(pso_pkg::REG_FIXED_THICK, 8'd0);
          write_reg(pso_pkg::REG_WIDTH_MODE, 8'd0);
        end
      endcase
      goal = vertices_sent + 32;
      while (vertices_sent < goal) begin
        send_random_polyline();
        if ($urandom_range(0, 9) == 0) wait_quiet();
      end
      wait_quiet();
    end

    if (mismatch_count == 0 && points_due == 0) begin
      $display("polyline_stroke_offsetter_tb: done, clean");
    end else begin
      $display("polyline_stroke_offsetter_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pso_pkg.sv
rtl/core/polyline_stroke_offsetter.sv
sim/strip_point_checker.sv
sim/polyline_stroke_offsetter_tb.sv
